/* sv/packet_delay_histogram_core_macros.svh */
// Assertion macros shared by the packet delay histogram RTL.
`ifndef PACKET_DELAY_HISTOGRAM_CORE_MACROS_SVH
`define PACKET_DELAY_HISTOGRAM_CORE_MACROS_SVH

// Checked property, disabled while reset is high.
`define PDH_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked property that also holds during reset.
`define PDH_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* sv/pdh_pkg.sv */
// Shared types and constants of the packet delay histogram.
`default_nettype none

package pdh_pkg;

   localparam int DIVIDEND_W = 48;
   localparam int DIVISOR_W  = 32;

   localparam logic [1:0] OP_PACKET  = 2'd0;
   localparam logic [1:0] OP_SUMMARY = 2'd1;
   localparam logic [1:0] OP_BIN     = 2'd2;

   localparam logic [1:0] CSR_RATE_FILTER = 2'd0;
   localparam logic [1:0] CSR_BIN_BASE    = 2'd1;
   localparam logic [1:0] CSR_BIN_WIDTH   = 2'd2;

   localparam logic [7:0]  RATE_FILTER_RESET = 8'd0;
   localparam logic [15:0] BIN_BASE_RESET    = 16'd200;
   localparam logic [9:0]  BIN_WIDTH_RESET   = 10'd10;

   localparam logic [31:0] ONES32   = 32'hFFFF_FFFF;
   localparam logic [47:0] DIFF_MAX = 48'hFFFF_FFFF_FFFF;

   typedef struct packed {
      logic                  busy;
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
   } div_res_type;

endpackage

`default_nettype wire

/* sv/pdh_divider.sv */
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none

module pdh_divider (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [pdh_pkg::DIVIDEND_W-1:0] dividend,
   input  wire logic [pdh_pkg::DIVISOR_W-1:0]  divisor,
   output pdh_pkg::div_res_type              res
);
   import pdh_pkg::*;

   localparam int CNT_W = $clog2(DIVIDEND_W);

   logic                  busy_ff;
   logic                  done_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [DIVIDEND_W-1:0] dvd_ff;
   logic [DIVISOR_W-1:0]  rem_ff;
   logic [DIVISOR_W-1:0]  dvs_ff;
   logic [DIVISOR_W:0]    rem_sh;
   logic [DIVISOR_W+1:0]  trial;
   logic                  fits;

   always_comb begin
      rem_sh = {rem_ff, dvd_ff[DIVIDEND_W-1]};
      trial  = {1'b0, rem_sh} - {2'b00, dvs_ff};
      fits   = !trial[DIVISOR_W+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DIVIDEND_W - 1);
            dvd_ff  <= dividend;
            dvs_ff  <= divisor;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            rem_ff <= fits ? trial[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
            dvd_ff <= {dvd_ff[DIVIDEND_W-2:0], fits};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign res.busy     = busy_ff;
   assign res.done     = done_ff;
   assign res.quotient = dvd_ff;

endmodule

`default_nettype wire

/* sv/pdh_bin_store.sv */
// Histogram bin memories (count and difference sum) with a clearing pass after reset.
`default_nettype none

module pdh_bin_store #(
   parameter int NUM_BINS = 1024
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   output logic                             clear_busy,
   input  wire logic                        wr_en,
   input  wire logic [$clog2(NUM_BINS)-1:0] wr_addr,
   input  wire logic [31:0]                 wr_count,
   input  wire logic [47:0]                 wr_diff,
   input  wire logic [$clog2(NUM_BINS)-1:0] rd_addr,
   output logic [31:0]                      rd_count,
   output logic [47:0]                      rd_diff
);
   import pdh_pkg::*;

   localparam int IDX_W = $clog2(NUM_BINS);

   logic [31:0]      count_mem [NUM_BINS];
   logic [47:0]      diff_mem  [NUM_BINS];
   logic             clr_busy_ff;
   logic [IDX_W-1:0] clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == IDX_W'(NUM_BINS - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         count_mem[clr_addr_ff] <= '0;
         diff_mem[clr_addr_ff]  <= '0;
      end else if (wr_en) begin
         count_mem[wr_addr] <= wr_count;
         diff_mem[wr_addr]  <= wr_diff;
      end
      rd_count <= count_mem[rd_addr];
      rd_diff  <= diff_mem[rd_addr];
   end

   assign clear_busy = clr_busy_ff;

endmodule

`default_nettype wire

/* sv/packet_delay_histogram_core.sv */
// Top level of the packet delay histogram: sequencer, statistics and result register.
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_stall  opcode, timestamps, record fields, bin select
//   rsp_     out        rsp_valid/rsp_stall  kind, delays, statistics, bin report
//   csr_     in         csr_valid/csr_ready  csr_index, csr_data
//
// A packet record passes through the shared 48-step divider, which finds the bin index,
// then one read-modify-write of the bin memories. A record at or below bin_base skips
// the divider. A bin read of an empty bin skips the divider; otherwise the divider splits
// the difference sum by the count. A summary first scans NUM_BINS bins, one read per
// cycle. Filtered, first and unused-opcode items end at accept. After reset the bins
// clear with req_stall high; a result waits in the output register, and only a second
// finished result stalls the sequencer.
`default_nettype none

`include "packet_delay_histogram_core_macros.svh"

module packet_delay_histogram_core #(
   parameter int NUM_BINS = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_opcode,
   input  wire logic [31:0] req_return_time,
   input  wire logic [31:0] req_queue_time,
   input  wire logic        req_dropped,
   input  wire logic [7:0]  req_rate_code,
   input  wire logic [7:0]  req_long_retries,
   input  wire logic [9:0]  req_bin_select,

   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_kind,
   output logic [31:0]      rsp_service_delay,
   output logic [31:0]      rsp_sojourn_delay,
   output logic [31:0]      rsp_least_delay,
   output logic [31:0]      rsp_delivered_count,
   output logic [31:0]      rsp_retry_sum,
   output logic [63:0]      rsp_service_total,
   output logic [63:0]      rsp_sojourn_total,
   output logic [31:0]      rsp_wraps,
   output logic [9:0]       rsp_bin_index,
   output logic [31:0]      rsp_bin_population,
   output logic [31:0]      rsp_run_span,

   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);
   import pdh_pkg::*;

   localparam int IDX_W = $clog2(NUM_BINS);
   localparam logic [IDX_W-1:0] LAST_BIN = IDX_W'(NUM_BINS - 1);

   typedef enum logic [3:0] {
      S_IDLE, S_CALC, S_DIV, S_BRD, S_BWAIT,
      S_SCAN, S_SCANL, S_FETCH, S_FWAIT, S_AVG, S_DONE
   } state_type;

   // Configuration registers.
   logic [7:0]  rate_filter_ff;
   logic [15:0] bin_base_ff;
   logic [9:0]  bin_width_ff;

   // Running statistics.
   logic        seen_first_ff;
   logic [31:0] prev_return_ff;
   logic [31:0] first_queue_ff;
   logic [31:0] lowest_queue_ff;
   logic [31:0] wrap_count_ff;
   logic [31:0] least_delay_ff;
   logic [31:0] delivered_ff;
   logic [31:0] retries_ff;
   logic [63:0] service_acc_ff;
   logic [63:0] sojourn_acc_ff;

   // Work registers of the item in flight.
   state_type        state_ff;
   logic [1:0]       kind_ff;
   logic [31:0]      svc_ff;
   logic [31:0]      soj_ff;
   logic             drop_ff;
   logic [7:0]       lr_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [31:0]      bound_ff;
   logic [31:0]      pop_ff;
   logic [31:0]      value_ff;
   logic [IDX_W-1:0] scan_ff;
   logic [IDX_W-1:0] cmp_idx_ff;
   logic             cmp_vld_ff;

   // Result register.
   logic        rsp_valid_ff;
   logic [1:0]  rsp_kind_ff;
   logic [31:0] rsp_svc_ff;
   logic [31:0] rsp_soj_ff;
   logic [31:0] rsp_min_ff;
   logic [31:0] rsp_deliv_ff;
   logic [31:0] rsp_retry_ff;
   logic [63:0] rsp_stot_ff;
   logic [63:0] rsp_jtot_ff;
   logic [31:0] rsp_wraps_ff;
   logic [9:0]  rsp_idx_ff;
   logic [31:0] rsp_pop_ff;
   logic [31:0] rsp_span_ff;

   // Memory and divider connections.
   logic             clear_busy;
   logic             wr_en;
   logic [31:0]      wr_count;
   logic [47:0]      wr_diff;
   logic [IDX_W-1:0] rd_addr;
   logic [31:0]      rd_count;
   logic [47:0]      rd_diff;
   logic             div_start;
   logic [47:0]      div_dividend;
   logic [31:0]      div_divisor;
   div_res_type      div_res;

   // Combinational helpers.
   logic             req_accept;
   logic [9:0]       eff_width;
   logic [IDX_W:0]   idx_p1;
   logic [31:0]      bound_in;
   logic             pass;
   logic [32:0]      retry_sum;
   logic [48:0]      diff_sum;
   logic [31:0]      svc_in;
   logic [IDX_W-1:0] sel_in;
   logic [IDX_W-1:0] best_in;
   logic [31:0]      pop_in;
   logic [IDX_W-1:0] bin_in;
   logic             rsp_free;
   logic [31:0]      idx_wide;

   pdh_bin_store #(.NUM_BINS(NUM_BINS)) u_store (
      .clock      (clock),
      .reset      (reset),
      .clear_busy (clear_busy),
      .wr_en      (wr_en),
      .wr_addr    (idx_ff),
      .wr_count   (wr_count),
      .wr_diff    (wr_diff),
      .rd_addr    (rd_addr),
      .rd_count   (rd_count),
      .rd_diff    (rd_diff)
   );

   pdh_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .res      (div_res)
   );

   assign req_stall  = clear_busy || (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      // A zero width acts as one.
      eff_width = (bin_width_ff == '0) ? 10'd1 : bin_width_ff;
      idx_p1    = {1'b0, idx_ff} + 1'b1;
      bound_in  = 32'(bin_base_ff) + 32'(idx_p1 * eff_width);

      pass      = (rate_filter_ff == '0) || (req_rate_code == rate_filter_ff);
      svc_in    = (req_queue_time >= prev_return_ff) ? (req_return_time - req_queue_time)
                                                     : (req_return_time - prev_return_ff);
      sel_in    = (32'(req_bin_select) > 32'(NUM_BINS - 1)) ? LAST_BIN
                                                            : IDX_W'(req_bin_select);

      retry_sum = {1'b0, retries_ff} + 33'(lr_ff);

      // Delays beyond the bin bound add nothing to the difference sum.
      diff_sum  = {1'b0, rd_diff};
      if (svc_ff <= bound_ff) begin
         diff_sum = {1'b0, rd_diff} + 49'(bound_ff - svc_ff);
      end
      wr_diff   = diff_sum[48] ? DIFF_MAX : diff_sum[47:0];
      wr_count  = (rd_count == ONES32) ? ONES32 : rd_count + 1'b1;
      wr_en     = (state_ff == S_BWAIT);

      // Running maximum of the scan; strict compare keeps the lowest index.
      best_in = idx_ff;
      pop_in  = pop_ff;
      if (cmp_vld_ff && (rd_count > pop_ff)) begin
         best_in = cmp_idx_ff;
         pop_in  = rd_count;
      end

      bin_in = (div_res.quotient > 48'(NUM_BINS - 1)) ? LAST_BIN
                                                      : IDX_W'(div_res.quotient);

      rd_addr = (state_ff == S_SCAN) ? scan_ff : idx_ff;

      div_start    = 1'b0;
      div_dividend = 48'(svc_ff - 32'(bin_base_ff) - 1'b1);
      div_divisor  = 32'(eff_width);
      if (state_ff == S_CALC) begin
         div_start = (svc_ff > 32'(bin_base_ff));
      end else if (state_ff == S_FWAIT) begin
         div_start    = (rd_count != '0);
         div_dividend = rd_diff;
         div_divisor  = rd_count;
      end

      idx_wide = 32'(idx_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_filter_ff <= RATE_FILTER_RESET;
         bin_base_ff    <= BIN_BASE_RESET;
         bin_width_ff   <= BIN_WIDTH_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_RATE_FILTER: rate_filter_ff <= csr_data[7:0];
            CSR_BIN_BASE:    bin_base_ff    <= csr_data;
            CSR_BIN_WIDTH:   bin_width_ff   <= csr_data[9:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         seen_first_ff   <= 1'b0;
         prev_return_ff  <= '0;
         first_queue_ff  <= '0;
         lowest_queue_ff <= '0;
         wrap_count_ff   <= '0;
         least_delay_ff  <= ONES32;
         delivered_ff    <= '0;
         retries_ff      <= '0;
         service_acc_ff  <= '0;
         sojourn_acc_ff  <= '0;
         cmp_vld_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         // In S_DONE the result register is reloaded instead whenever it is taken.
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  kind_ff <= req_opcode;
                  unique case (req_opcode)
                     OP_PACKET: begin
                        prev_return_ff <= req_return_time;
                        svc_ff         <= svc_in;
                        soj_ff         <= req_return_time - req_queue_time;
                        drop_ff        <= req_dropped;
                        lr_ff          <= req_long_retries;
                        if (!seen_first_ff) begin
                           seen_first_ff   <= 1'b1;
                           first_queue_ff  <= req_queue_time;
                           lowest_queue_ff <= req_queue_time;
                        end else begin
                           // A queue time below the lowest one seen so far marks a timestamp wrap.
                           if (req_queue_time < lowest_queue_ff) begin
                              lowest_queue_ff <= req_queue_time;
                              wrap_count_ff   <= wrap_count_ff + 1'b1;
                           end
                           if (pass) begin
                              state_ff <= S_CALC;
                           end
                        end
                     end
                     OP_SUMMARY: begin
                        scan_ff    <= '0;
                        idx_ff     <= '0;
                        pop_ff     <= '0;
                        cmp_vld_ff <= 1'b0;
                        state_ff   <= S_SCAN;
                     end
                     OP_BIN: begin
                        idx_ff   <= sel_in;
                        state_ff <= S_FETCH;
                     end
                     default: ;
                  endcase
               end
            end

            S_CALC: begin
               if (svc_ff < least_delay_ff) begin
                  least_delay_ff <= svc_ff;
               end
               service_acc_ff <= service_acc_ff + 64'(svc_ff);
               sojourn_acc_ff <= sojourn_acc_ff + 64'(soj_ff);
               if (!drop_ff && (delivered_ff != ONES32)) begin
                  delivered_ff <= delivered_ff + 1'b1;
               end
               retries_ff <= retry_sum[32] ? ONES32 : retry_sum[31:0];
               if (svc_ff > 32'(bin_base_ff)) begin
                  state_ff <= S_DIV;
               end else begin
                  idx_ff   <= '0;
                  state_ff <= S_BRD;
               end
            end

            S_DIV: begin
               if (div_res.done) begin
                  idx_ff   <= bin_in;
                  state_ff <= S_BRD;
               end
            end

            S_BRD: begin
               bound_ff <= bound_in;
               state_ff <= S_BWAIT;
            end

            S_BWAIT: begin
               pop_ff   <= wr_count;
               value_ff <= svc_ff;
               state_ff <= S_DONE;
            end

            S_SCAN: begin
               cmp_vld_ff <= 1'b1;
               cmp_idx_ff <= scan_ff;
               scan_ff    <= scan_ff + 1'b1;
               idx_ff     <= best_in;
               pop_ff     <= pop_in;
               if (scan_ff == LAST_BIN) begin
                  state_ff <= S_SCANL;
               end
            end

            S_SCANL: begin
               cmp_vld_ff <= 1'b0;
               idx_ff     <= best_in;
               pop_ff     <= pop_in;
               state_ff   <= S_FETCH;
            end

            S_FETCH: begin
               bound_ff <= bound_in;
               state_ff <= S_FWAIT;
            end

            S_FWAIT: begin
               pop_ff <= rd_count;
               soj_ff <= '0;
               // An empty bin reports its upper bound.
               if (rd_count == '0) begin
                  value_ff <= bound_ff;
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_AVG;
               end
            end

            S_AVG: begin
               if (div_res.done) begin
                  value_ff <= bound_ff - div_res.quotient[31:0];
                  state_ff <= S_DONE;
               end
            end

            S_DONE: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_kind_ff  <= kind_ff;
                  rsp_svc_ff   <= value_ff;
                  rsp_soj_ff   <= soj_ff;
                  rsp_min_ff   <= least_delay_ff;
                  rsp_deliv_ff <= delivered_ff;
                  rsp_retry_ff <= retries_ff;
                  rsp_stot_ff  <= service_acc_ff;
                  rsp_jtot_ff  <= sojourn_acc_ff;
                  rsp_wraps_ff <= wrap_count_ff;
                  rsp_idx_ff   <= idx_wide[9:0];
                  rsp_pop_ff   <= pop_ff;
                  rsp_span_ff  <= prev_return_ff - first_queue_ff;
                  state_ff     <= S_IDLE;
               end
            end

            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_kind            = rsp_kind_ff;
   assign rsp_service_delay   = rsp_svc_ff;
   assign rsp_sojourn_delay   = rsp_soj_ff;
   assign rsp_least_delay     = rsp_min_ff;
   assign rsp_delivered_count = rsp_deliv_ff;
   assign rsp_retry_sum       = rsp_retry_ff;
   assign rsp_service_total   = rsp_stot_ff;
   assign rsp_sojourn_total   = rsp_jtot_ff;
   assign rsp_wraps           = rsp_wraps_ff;
   assign rsp_bin_index       = rsp_idx_ff;
   assign rsp_bin_population  = rsp_pop_ff;
   assign rsp_run_span        = rsp_span_ff;

   // The bin memories are never updated by the sequencer during the clearing pass.
   `PDH_ASSERT(a_no_write_in_clear, wr_en |-> !clear_busy, "bin write during clear")

   // A finished result waits while the output register is still occupied.
   `PDH_ASSERT(a_done_holds, (state_ff == S_DONE && !rsp_free) |=> (state_ff == S_DONE), "result lost")

   // The divider is only started when it is idle.
   `PDH_ASSERT(a_div_idle_start, div_start |-> !div_res.busy, "divider restarted while busy")

endmodule

`default_nettype wire

/* tb/tb_packet_delay_histogram_core.sv */
// Self-checking testbench for the packet delay histogram core.
`default_nettype none

module tb_packet_delay_histogram_core;
   timeunit 1ns;
   timeprecision 1ps;

   import pdh_pkg::*;

   localparam int NBINS       = 1024;
   localparam int CYCLE_LIMIT = 2000000;
   // One summary read scans every bin, so the block can be busy well past the last result.
   localparam int DRAIN_WAIT  = 1200;
   localparam int LONG_HOLD   = 3000;
   localparam int PHASE_ITEMS = 286;
   // The one opcode that the block ignores.
   localparam logic [1:0] OP_SPARE = 2'd3;

   // One input item as the sender offers it.
   typedef struct {
      logic [1:0]  op;
      logic [31:0] rt;
      logic [31:0] qt;
      logic        drop;
      logic [7:0]  rc;
      logic [7:0]  lr;
      logic [9:0]  sel;
   } req_type;

   // One result item as the block should deliver it.
   typedef struct {
      logic [1:0]  kind;
      logic [31:0] svc;
      logic [31:0] soj;
      logic [31:0] min_d;
      logic [31:0] deliv;
      logic [31:0] retr;
      logic [63:0] svc_tot;
      logic [63:0] soj_tot;
      logic [31:0] wraps;
      logic [9:0]  idx;
      logic [31:0] pop;
      logic [31:0] span;
   } rsp_type;

   // One row of the directed table; the typed fields are used where chk is set.
   typedef struct {
      req_type     it;
      bit          chk;
      logic [1:0]  kind;
      logic [31:0] svc;
      logic [9:0]  idx;
      logic [31:0] pop;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_opcode = '0;
   logic [31:0] req_return_time = '0;
   logic [31:0] req_queue_time = '0;
   logic        req_dropped = 1'b0;
   logic [7:0]  req_rate_code = '0;
   logic [7:0]  req_long_retries = '0;
   logic [9:0]  req_bin_select = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic [31:0] rsp_service_delay;
   logic [31:0] rsp_sojourn_delay;
   logic [31:0] rsp_least_delay;
   logic [31:0] rsp_delivered_count;
   logic [31:0] rsp_retry_sum;
   logic [63:0] rsp_service_total;
   logic [63:0] rsp_sojourn_total;
   logic [31:0] rsp_wraps;
   logic [9:0]  rsp_bin_index;
   logic [31:0] rsp_bin_population;
   logic [31:0] rsp_run_span;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   packet_delay_histogram_core #(.NUM_BINS(NBINS)) u_dut (.*);

   always #1 clock = ~clock;

   // Shadow copy of the configuration registers.
   logic [7:0]  sh_rate_filter;
   logic [15:0] sh_bin_base;
   logic [9:0]  sh_bin_width;

   // Shadow copy of the statistics and the histogram.
   bit          sh_seen_first;
   logic [31:0] sh_prev_return, sh_first_queue, sh_lowest_queue, sh_wrap_count;
   logic [31:0] sh_least_delay, sh_delivered, sh_retries;
   logic [63:0] sh_service_acc, sh_sojourn_acc;
   logic [31:0] sh_bin_count [NBINS];
   logic [47:0] sh_bin_diff [NBINS];

   rsp_type     pending_rsp[$];
   int          errors = 0;
   int          cycles = 0;

   // Sender and receiver pacing: calm turns off random idling on both sides.
   bit          calm = 0;
   bit          hold_req = 0;
   int          hold_left = 0;
   int          rsp_gap = 0;

   // Generator bookkeeping so that packet records form a plausible timeline.
   logic [31:0] gen_last_rt = 32'd5000;

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("error: %s got %0h expected %0h", what, got, want);
      errors++;
   endtask

   function automatic logic [63:0] eff_width();
      return (sh_bin_width == 0) ? 64'd1 : 64'(sh_bin_width);
   endfunction

   function automatic logic [63:0] bound_of(input logic [63:0] idx);
      return 64'(sh_bin_base) + (idx + 64'd1) * eff_width();
   endfunction

   function automatic logic [31:0] bin_mean(input int idx);
      logic [63:0] b;
      b = bound_of(64'(idx));
      if (sh_bin_count[idx] == 0)
         return b[31:0];
      b = b - 64'(sh_bin_diff[idx]) / 64'(sh_bin_count[idx]);
      return b[31:0];
   endfunction

   // Advance the shadow state by one item; returns 1 when a result is due.
   function automatic bit histogram_step(input req_type it, output rsp_type r);
      logic [31:0] svc, soj;
      logic [63:0] j, b, s, rsum;
      int          best;
      bit          due;
      due = 0;
      r = '{default: '0};
      case (it.op)
         OP_PACKET: begin
            if (!sh_seen_first) begin
               sh_seen_first   = 1;
               sh_first_queue  = it.qt;
               sh_lowest_queue = it.qt;
            end else begin
               svc = (it.qt >= sh_prev_return) ? it.rt - it.qt : it.rt - sh_prev_return;
               soj = it.rt - it.qt;
               if (sh_rate_filter == 0 || it.rc == sh_rate_filter) begin
                  if (svc < sh_least_delay) sh_least_delay = svc;
                  sh_service_acc += 64'(svc);
                  sh_sojourn_acc += 64'(soj);
                  if (!it.drop && sh_delivered != ONES32) sh_delivered++;
                  rsum = 64'(sh_retries) + 64'(it.lr);
                  sh_retries = (rsum > 64'(ONES32)) ? ONES32 : rsum[31:0];
                  if (64'(svc) <= 64'(sh_bin_base))
                     j = 0;
                  else
                     j = (64'(svc) - 64'(sh_bin_base) - 64'd1) / eff_width();
                  if (j > NBINS - 1) j = NBINS - 1;
                  b = bound_of(j);
                  // Delays past the last bound land in the last bin without a difference.
                  if (64'(svc) <= b) begin
                     s = 64'(sh_bin_diff[j]) + (b - 64'(svc));
                     sh_bin_diff[j] = (s > 64'(DIFF_MAX)) ? DIFF_MAX : s[47:0];
                  end
                  if (sh_bin_count[j] != ONES32) sh_bin_count[j]++;
                  r.kind = OP_PACKET;
                  r.svc  = svc;
                  r.soj  = soj;
                  r.idx  = j[9:0];
                  r.pop  = sh_bin_count[j];
                  due    = 1;
               end
            end
            if (it.qt < sh_lowest_queue) begin
               sh_lowest_queue = it.qt;
               sh_wrap_count++;
            end
            sh_prev_return = it.rt;
         end
         OP_SUMMARY: begin
            best = 0;
            for (int i = 1; i < NBINS; i++)
               if (sh_bin_count[i] > sh_bin_count[best]) best = i;
            r.kind = OP_SUMMARY;
            r.svc  = bin_mean(best);
            r.idx  = best[9:0];
            r.pop  = sh_bin_count[best];
            due    = 1;
         end
         OP_BIN: begin
            best   = (int'(it.sel) > NBINS - 1) ? NBINS - 1 : int'(it.sel);
            r.kind = OP_BIN;
            r.svc  = bin_mean(best);
            r.idx  = best[9:0];
            r.pop  = sh_bin_count[best];
            due    = 1;
         end
         default: ;
      endcase
      if (due) begin
         r.min_d   = sh_least_delay;
         r.deliv   = sh_delivered;
         r.retr    = sh_retries;
         r.svc_tot = sh_service_acc;
         r.soj_tot = sh_sojourn_acc;
         r.wraps   = sh_wrap_count;
         r.span    = sh_prev_return - sh_first_queue;
      end
      return due;
   endfunction

   // Offer one item, wait until it is taken, and queue what it should produce.
   task automatic send_req(input req_type it, input bit chk, input logic [1:0] kind,
                           input logic [31:0] svc, input logic [9:0] idx,
                           input logic [31:0] pop);
      int      gap;
      rsp_type r;
      gap = calm ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_opcode       <= it.op;
      req_return_time  <= it.rt;
      req_queue_time   <= it.qt;
      req_dropped      <= it.drop;
      req_rate_code    <= it.rc;
      req_long_retries <= it.lr;
      req_bin_select   <= it.sel;
      req_valid        <= 1'b1;
      do @(posedge clock); while (req_stall);
      if (histogram_step(it, r)) begin
         if (chk) begin
            r.kind = kind;
            r.svc  = svc;
            r.idx  = idx;
            r.pop  = pop;
         end
         pending_rsp.push_back(r);
      end
      @(negedge clock);
   endtask

   // Each write ends on a falling edge with valid still high; the caller lowers it.
   task automatic write_csr(input logic [1:0] idx, input logic [15:0] val);
      csr_index <= idx;
      csr_data  <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_RATE_FILTER: sh_rate_filter = val[7:0];
         CSR_BIN_BASE:    sh_bin_base    = val;
         CSR_BIN_WIDTH:   sh_bin_width   = val[9:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Wait for every expected result, then for the block to finish any silent work.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic req_type rand_item();
      req_type     it;
      int          pick;
      logic [31:0] d;
      it.op   = OP_PACKET;
      it.rt   = $urandom;
      it.qt   = $urandom;
      it.drop = 1'($urandom_range(0, 1));
      it.rc   = 8'($urandom);
      it.lr   = ($urandom_range(0, 9) == 0) ? 8'hFF : 8'($urandom);
      it.sel  = ($urandom_range(0, 1) == 0) ? 10'($urandom) : 10'($urandom_range(0, 40));
      pick    = $urandom_range(0, 99);
      if (pick < 3) begin
         it.op = OP_SPARE;
      end else if (pick < 6) begin
         it.op = OP_SUMMARY;
      end else if (pick < 18) begin
         it.op = OP_BIN;
      end else begin
         if (sh_rate_filter != 0 && $urandom_range(0, 9) < 7) it.rc = sh_rate_filter;
         if ($urandom_range(0, 19) != 0) begin
            // Mostly a timeline: queue just after or just before the previous return.
            if ($urandom_range(0, 4) == 0)
               it.qt = gen_last_rt - $urandom_range(1, 500);
            else
               it.qt = gen_last_rt + $urandom_range(0, 300);
            if ($urandom_range(0, 19) == 0)
               d = $urandom;
            else if ($urandom_range(0, 9) == 0)
               d = $urandom_range(0, 32'(sh_bin_base));
            else
               d = 32'(sh_bin_base) + $urandom_range(0, 40 * 32'(eff_width()));
            it.rt = it.qt + d;
         end
         gen_last_rt = it.rt;
      end
      return it;
   endfunction

   // Run length and timeout.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("packet_delay_histogram_core: mismatch");
         $finish;
      end
   end

   // Receiver pacing: a random gap before each result, or one long hold-off on request.
   always @(negedge clock) begin
      if (hold_req) begin
         hold_left = LONG_HOLD;
         hold_req  = 0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (rsp_gap > 0) begin
         rsp_stall <= 1'b1;
         rsp_gap--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Result checker: every taken result is matched against the oldest expectation.
   always @(posedge clock) begin
      rsp_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_gap = calm ? 0 : $urandom_range(0, 9);
         if (pending_rsp.size() == 0) begin
            report("unexpected result kind", 64'(rsp_kind), 64'd0);
         end else begin
            w = pending_rsp.pop_front();
            if (rsp_kind !== w.kind) report("kind", 64'(rsp_kind), 64'(w.kind));
            if (rsp_service_delay !== w.svc)
               report("service_delay", 64'(rsp_service_delay), 64'(w.svc));
            if (rsp_sojourn_delay !== w.soj)
               report("sojourn_delay", 64'(rsp_sojourn_delay), 64'(w.soj));
            if (rsp_least_delay !== w.min_d)
               report("least_delay", 64'(rsp_least_delay), 64'(w.min_d));
            if (rsp_delivered_count !== w.deliv)
               report("delivered_count", 64'(rsp_delivered_count), 64'(w.deliv));
            if (rsp_retry_sum !== w.retr)
               report("retry_sum", 64'(rsp_retry_sum), 64'(w.retr));
            if (rsp_service_total !== w.svc_tot)
               report("service_total", rsp_service_total, w.svc_tot);
            if (rsp_sojourn_total !== w.soj_tot)
               report("sojourn_total", rsp_sojourn_total, w.soj_tot);
            if (rsp_wraps !== w.wraps) report("wraps", 64'(rsp_wraps), 64'(w.wraps));
            if (rsp_bin_index !== w.idx)
               report("bin_index", 64'(rsp_bin_index), 64'(w.idx));
            if (rsp_bin_population !== w.pop)
               report("bin_population", 64'(rsp_bin_population), 64'(w.pop));
            if (rsp_run_span !== w.span)
               report("run_span", 64'(rsp_run_span), 64'(w.span));
         end
      end
   end

   function automatic row_type mk(input logic [1:0] op, input logic [31:0] rt,
                                  input logic [31:0] qt, input logic drop,
                                  input logic [7:0] rc, input logic [7:0] lr,
                                  input logic [9:0] sel, input bit chk,
                                  input logic [31:0] svc, input logic [31:0] pop);
      row_type r;
      r.it   = '{op: op, rt: rt, qt: qt, drop: drop, rc: rc, lr: lr, sel: sel};
      r.chk  = chk;
      r.kind = op;
      r.svc  = svc;
      r.idx  = (op == OP_PACKET) ? 10'd0 : sel;
      r.pop  = pop;
      return r;
   endfunction

   // Directed items run at the reset configuration; the stimulus phases follow.
   initial begin
      row_type     rows[$];
      row_type     rw;
      logic [7:0]  ph_rate [5];
      logic [15:0] ph_base [5];
      logic [15:0] ph_width[5];

      ph_rate  = '{8'd0, 8'd5, 8'd255, 8'd0, 8'd3};
      ph_base  = '{16'd200, 16'd0, 16'hFFFF, 16'd0, 16'hFC64};
      ph_width = '{16'd10, 16'd1, 16'h03FF, 16'hFFFF, 16'hFC00};

      sh_rate_filter  = RATE_FILTER_RESET;
      sh_bin_base     = BIN_BASE_RESET;
      sh_bin_width    = BIN_WIDTH_RESET;
      sh_seen_first   = 0;
      sh_prev_return  = '0;
      sh_first_queue  = '0;
      sh_lowest_queue = '0;
      sh_wrap_count   = '0;
      sh_least_delay  = ONES32;
      sh_delivered    = '0;
      sh_retries      = '0;
      sh_service_acc  = '0;
      sh_sojourn_acc  = '0;
      for (int i = 0; i < NBINS; i++) begin
         sh_bin_count[i] = '0;
         sh_bin_diff[i]  = '0;
      end

      // Empty histogram: bins report their upper bound, the summary picks bin zero.
      rows.push_back(mk(OP_BIN, 0, 0, 0, 0, 0, 10'd0, 1, 32'd210, 0));
      rows.push_back(mk(OP_BIN, 0, 0, 0, 0, 0, 10'd1023, 1, 32'd10440, 0));
      rows.push_back(mk(OP_SUMMARY, 0, 0, 0, 0, 0, 10'd0, 1, 32'd210, 0));
      // The unused opcode changes nothing.
      rows.push_back(mk(OP_SPARE, 32'hFFFF_FFFF, 32'd7, 1, 8'hFF, 8'hFF, 10'h3FF, 0, 0, 0));
      // The first record only starts the run.
      rows.push_back(mk(OP_PACKET, 32'd1500, 32'd1000, 0, 8'd1, 8'd2, 10'd0, 0, 0, 0));
      rows.push_back(mk(OP_PACKET, 32'd2205, 32'd2000, 0, 8'd1, 8'd0, 10'd0, 0, 0, 0));
      // Queue time before the previous return: delay counts from that return.
      rows.push_back(mk(OP_PACKET, 32'd2500, 32'd2100, 1, 8'd9, 8'd3, 10'd0, 0, 0, 0));
      // Delay far above the top bin lands in the last bin.
      rows.push_back(mk(OP_PACKET, 32'hF000_0BB8, 32'd3000, 0, 8'd2, 8'hFF, 10'd0, 0, 0, 0));
      rows.push_back(mk(OP_PACKET, 32'hF000_1000, 32'hF000_1000, 0, 8'd0, 8'd0, 10'd0, 0, 0, 0));
      // Queue time zero is a wrap; the return at all ones gives the largest sojourn.
      rows.push_back(mk(OP_PACKET, 32'hFFFF_FFFF, 32'd0, 1, 8'hFF, 8'hFF, 10'd0, 0, 0, 0));
      rows.push_back(mk(OP_PACKET, 32'd0, 32'hFFFF_FFFF, 0, 8'h80, 8'h7F, 10'd0, 0, 0, 0));
      rows.push_back(mk(OP_PACKET, 32'd230, 32'd10, 0, 8'h55, 8'hAA, 10'd0, 0, 0, 0));
      rows.push_back(mk(OP_PACKET, 32'd460, 32'd240, 1, 8'hAA, 8'h55, 10'd0, 0, 0, 0));
      rows.push_back(mk(OP_BIN, 0, 0, 0, 0, 0, 10'd0, 0, 0, 0));
      rows.push_back(mk(OP_BIN, 0, 0, 0, 0, 0, 10'd1, 0, 0, 0));
      rows.push_back(mk(OP_BIN, 0, 0, 0, 0, 0, 10'd9, 0, 0, 0));
      rows.push_back(mk(OP_BIN, 0, 0, 0, 0, 0, 10'd1023, 0, 0, 0));
      rows.push_back(mk(OP_BIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 8'hFF, 8'hFF, 10'h2AA,
                        0, 0, 0));
      rows.push_back(mk(OP_SUMMARY, 0, 0, 0, 0, 0, 10'h3FF, 0, 0, 0));

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // The block clears its bins before taking items; send_req simply waits on stall.
      foreach (rows[k]) begin
         rw = rows[k];
         send_req(rw.it, rw.chk, rw.kind, rw.svc, rw.idx, rw.pop);
      end
      gen_last_rt = sh_prev_return;

      for (int p = 0; p < 5; p++) begin
         drain();
         write_csr(CSR_RATE_FILTER, {8'h00, ph_rate[p]});
         write_csr(CSR_BIN_BASE, ph_base[p]);
         write_csr(CSR_BIN_WIDTH, ph_width[p]);
         csr_valid <= 1'b0;
         // One phase runs without idling on either side.
         calm = (p == 2);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Hold results off for a long stretch so that the block backs up.
            if (p == 1 && n == 20) hold_req = 1;
            send_req(rand_item(), 0, '0, '0, '0, '0);
         end
      end
      drain();

      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("packet_delay_histogram_core: match");
      end else begin
         $display("packet_delay_histogram_core: mismatch");
      end
      $finish;
   end

endmodule

`default_nettype wire
